FILE: rtl/core/srrs_pkg.sv
// Package of the sparse transpose row remap and sort core: sizes, item and control types.
`default_nettype none

package srrs_pkg;

    // Storage and field sizes.
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = 16;
    localparam int DIM_W       = 16;
    localparam int VAL_W       = 64;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DIV_CNT_W   = $clog2(IDX_W);

    // One input item.
    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [VAL_W-1:0] entry_value;
        logic             column_end;
    } srrs_in_t;

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0] new_row_index;
        logic [VAL_W-1:0] out_value;
        logic             last_of_column;
        logic             overflow;
        logic             out_of_range;
    } srrs_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_range;
        logic mul_key;
        logic add_key;
        logic ins_start;
        logic ins_step;
        logic put;
        logic mark_ovf;
        logic out_start;
        logic out_load;
        logic out_next;
        logic col_clear;
    } srrs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic full;
        logic empty;
        logic shift;
        logic pos_zero;
        logic end_col;
        logic out_taken;
        logic out_last;
    } srrs_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sparse_transpose_row_remap_sort_core.sv
// Top level of the sparse transpose row remap and sort core.
`default_nettype none

// The core takes the nonzero entries of one sparse matrix column, one item
// at a time, and remaps each row index r to its transposed position
// (r mod rows_a) * cols_a + r div rows_a, saturated to 16 bits. The pairs of
// remapped index and 64-bit value are kept in ascending index order by
// insertion, with equal indices in arrival order. When the item flagged
// column_end has been stored, the column is sent out in ascending order and
// its final result is marked last_of_column. A column holds at most 64 pairs;
// further entries are dropped and raise overflow on every result of that
// column, while an index at or above rows_a * cols_a, or a remapped index that
// had to be saturated, raises out_of_range. A zero rows_a counts as one.
// The core works on one item at a time. The time that an item takes is set
// by the 16-step restoring divider, the shared 16x16 multiplier used twice,
// and the walk through the pair store, which moves up one place each stored
// pair with a greater index; there is no walk when the store is empty or
// already full. At a column end the results are then sent out one at a time,
// each loaded once the previous one has been taken. Write the rows_a register
// at byte address 0 and cols_a at byte address 4, only while the core is
// idle; both reset to one.

module sparse_transpose_row_remap_sort_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire srrs_pkg::srrs_in_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output srrs_pkg::srrs_out_t      out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);
    import srrs_pkg::*;

    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    srrs_cmd_t        cmd;
    srrs_stat_t       stat;

    // Configuration registers.
    srrs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows_a  (rows_a),
        .cols_a  (cols_a)
    );

    // The controller accepts an item only when idle and steps the datapath.
    srrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the divider, multiplier, pair store and result register.
    srrs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .rows_a    (rows_a),
        .cols_a    (cols_a),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

FILE: rtl/core/srrs_regs.sv
// Configuration register file of the remap core, reached through an APB-style port.
`default_nettype none

module srrs_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [srrs_pkg::DIM_W-1:0] rows_a,
    output logic      [srrs_pkg::DIM_W-1:0] cols_a
);
    import srrs_pkg::*;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(1);
            cols_reg <= DIM_W'(1);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ROWS: rows_reg <= pwdata[DIM_W-1:0];
                REG_COLS: cols_reg <= pwdata[DIM_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS: prdata = 32'(rows_reg);
            REG_COLS: prdata = 32'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    assign rows_a = rows_reg;
    assign cols_a = cols_reg;

endmodule

`default_nettype wire

FILE: rtl/core/srrs_ctrl.sv
// Controller state machine that sequences division, remap, sorted insertion and emission.
`default_nettype none

module srrs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire srrs_pkg::srrs_stat_t stat,
    output srrs_pkg::srrs_cmd_t       cmd
);
    import srrs_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV      = 4'd1;
    localparam logic [3:0] ST_MULR     = 4'd2;
    localparam logic [3:0] ST_MULK     = 4'd3;
    localparam logic [3:0] ST_ADDK     = 4'd4;
    localparam logic [3:0] ST_INS      = 4'd5;
    localparam logic [3:0] ST_INS_CMP  = 4'd6;
    localparam logic [3:0] ST_INS_PUT  = 4'd7;
    localparam logic [3:0] ST_FINISH   = 4'd8;
    localparam logic [3:0] ST_OUT_LOAD = 4'd9;
    localparam logic [3:0] ST_OUT_WAIT = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_MULR;
                end
            end
            ST_MULR:
            begin
                cmd.mul_range = 1'b1;
                state_next    = ST_MULK;
            end
            ST_MULK:
            begin
                cmd.mul_key = 1'b1;
                state_next  = ST_ADDK;
            end
            ST_ADDK:
            begin
                cmd.add_key = 1'b1;
                state_next  = ST_INS;
            end
            ST_INS:
            begin
                if (stat.full)
                begin
                    cmd.mark_ovf = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (stat.empty)
                begin
                    cmd.put    = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                cmd.ins_step = 1'b1;
                if (!stat.shift)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.pos_zero)
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.end_col)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.empty)
                begin
                    cmd.col_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.out_start = 1'b1;
                    state_next    = ST_OUT_LOAD;
                end
            end
            ST_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.out_last)
                    begin
                        cmd.col_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/srrs_dpath.sv
// Datapath: restoring divider, shared multiplier, sorted pair store and result register.
`default_nettype none

module srrs_dpath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire srrs_pkg::srrs_cmd_t        cmd,
    output srrs_pkg::srrs_stat_t            stat,
    input  wire srrs_pkg::srrs_in_t         in_item,
    input  wire logic [srrs_pkg::DIM_W-1:0] rows_a,
    input  wire logic [srrs_pkg::DIM_W-1:0] cols_a,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output srrs_pkg::srrs_out_t             out_item
);
    import srrs_pkg::*;

    // Pair store.
    logic [IDX_W-1:0] key_mem [MAX_ENTRIES];
    logic [VAL_W-1:0] val_mem [MAX_ENTRIES];

    // Captured item and dimensions.
    logic [IDX_W-1:0]     r_reg;
    logic [VAL_W-1:0]     val_reg;
    logic                 end_reg;
    logic [DIM_W-1:0]     rows_reg;
    logic [DIM_W-1:0]     cols_reg;

    // Divider, multiplier and key.
    logic [DIM_W-1:0]     rem_reg;
    logic [IDX_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [IDX_W-1:0]     key_reg;

    // Column bookkeeping.
    logic [CNT_W-1:0]     count_reg;
    logic [ADDR_W-1:0]    pos_reg;
    logic [ADDR_W-1:0]    k_reg;
    logic                 ovf_reg;
    logic                 rng_reg;

    // Registered read port and result register.
    logic [IDX_W-1:0]     rd_key_reg;
    logic [VAL_W-1:0]     rd_val_reg;
    srrs_out_t            out_reg;
    logic                 out_valid_reg;

    logic [DIM_W:0]       trial;
    logic                 trial_ge;
    logic [DIM_W:0]       trial_diff;
    logic [DIM_W-1:0]     mul_a;
    logic [PROD_W:0]      key_sum;
    logic                 shift;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [IDX_W-1:0]     wr_key;
    logic [VAL_W-1:0]     wr_val;
    logic [ADDR_W-1:0]    last_addr;
    logic                 out_taken;

    // One restoring division step per cycle.
    assign trial      = {rem_reg, quo_reg[IDX_W-1]};
    assign trial_ge   = (trial >= {1'b0, rows_reg});
    assign trial_diff = trial - {1'b0, rows_reg};

    assign mul_a   = cmd.mul_range ? rows_reg : rem_reg;
    assign key_sum = {1'b0, prod_reg} + (PROD_W + 1)'(quo_reg);

    assign shift     = (rd_key_reg > key_reg);
    assign last_addr = ADDR_W'(count_reg - CNT_W'(1));
    assign out_taken = out_valid_reg && !out_stall;

    // Read address of the pair store.
    always_comb
    begin
        rd_en   = cmd.ins_start || cmd.ins_step || cmd.out_start || cmd.out_next;
        rd_addr = pos_reg;
        if (cmd.ins_start)
        begin
            rd_addr = last_addr;
        end
        else if (cmd.ins_step)
        begin
            rd_addr = pos_reg - ADDR_W'(1);
        end
        else if (cmd.out_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.out_next)
        begin
            rd_addr = k_reg + ADDR_W'(1);
        end
    end

    // Write port: move an entry up one place, or place the new pair.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg + ADDR_W'(1);
        wr_key  = key_reg;
        wr_val  = val_reg;
        if (cmd.ins_step)
        begin
            wr_en = 1'b1;
            if (shift)
            begin
                wr_key = rd_key_reg;
                wr_val = rd_val_reg;
            end
        end
        else if (cmd.put)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg       <= in_item.row_index;
            val_reg     <= in_item.entry_value;
            end_reg     <= in_item.column_end;
            rows_reg    <= (rows_a == '0) ? DIM_W'(1) : rows_a;
            cols_reg    <= cols_a;
            rem_reg     <= '0;
            quo_reg     <= in_item.row_index;
            div_cnt_reg <= DIV_CNT_W'(IDX_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? trial_diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quo_reg     <= {quo_reg[IDX_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.mul_range || cmd.mul_key)
        begin
            prod_reg <= mul_a * cols_reg;
        end
        if (cmd.add_key)
        begin
            if (key_sum[PROD_W:IDX_W] != '0)
            begin
                key_reg <= '1;
            end
            else
            begin
                key_reg <= key_sum[IDX_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_reg.new_row_index  <= rd_key_reg;
            out_reg.out_value      <= rd_val_reg;
            out_reg.last_of_column <= (k_reg == last_addr);
            out_reg.overflow       <= ovf_reg;
            out_reg.out_of_range   <= rng_reg;
        end
    end

    // Control registers of the column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            rng_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.col_clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                rng_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.put || (cmd.ins_step && !shift))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (cmd.mark_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
                if (cmd.mul_key && ({{(PROD_W - IDX_W){1'b0}}, r_reg} >= prod_reg))
                begin
                    rng_reg <= 1'b1;
                end
                if (cmd.add_key && (key_sum[PROD_W:IDX_W] != '0))
                begin
                    rng_reg <= 1'b1;
                end
            end
            if (cmd.ins_start)
            begin
                pos_reg <= last_addr;
            end
            else if (cmd.ins_step && shift && (pos_reg != '0))
            begin
                pos_reg <= pos_reg - ADDR_W'(1);
            end
            if (cmd.out_start)
            begin
                k_reg <= '0;
            end
            else if (cmd.out_next)
            begin
                k_reg <= k_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.div_last  = (div_cnt_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(MAX_ENTRIES));
    assign stat.empty     = (count_reg == '0);
    assign stat.shift     = shift;
    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.end_col   = end_reg;
    assign stat.out_taken = out_taken;
    assign stat.out_last  = out_reg.last_of_column;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The store never holds more pairs than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("pair count above capacity");

    // A new pair is placed only while the store has room.
    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put || cmd.ins_start) |-> (count_reg < CNT_W'(MAX_ENTRIES)))
        else $error("insertion into a full store");

    // The insertion scan stays inside the filled part of the store.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_step |-> ({1'b0, pos_reg} < count_reg))
        else $error("insertion scan beyond filled entries");

    // Emission reads only filled entries.
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> ({1'b0, k_reg} < count_reg))
        else $error("emission beyond filled entries");

    // A new result is loaded only once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("result register overwritten");

endmodule

`default_nettype wire
